/* design/linear_probe_handle_table_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the linear-probe handle table
// Shared property forms, clocked on i_clk with active-low i_rst_n.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HANDLE_TABLE_UNIT_MACROS_SVH
`define LINEAR_PROBE_HANDLE_TABLE_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define LPHT_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lpht: same-cycle check failed");

// next-cycle implication, off during reset
`define LPHT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lpht: next-cycle check failed");

// next-cycle implication, active during reset
`define LPHT_ASSERT_RESET(name, ante, cons) \
    name: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("lpht: reset check failed");

`endif

/* design/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// Sizes, codes and controller/datapath bundles of the handle table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    localparam int TABLE_SIZE = 128;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
    localparam int HANDLE_W   = 16;
    localparam int IDX_W      = 7;
    localparam int RES_W      = 7;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT  = 2'd0,
        KIND_FIND    = 2'd1,
        KIND_RELEASE = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_ADDR = 2'd1,
        RES_CHK  = 2'd2
    } t_res_sel;

    typedef struct packed {
        logic     start;
        logic     probe_init;
        logic     ins_step;
        logic     ins_write;
        logic     find_en;
        logic     rel_write;
        logic     res_load;
        t_res_sel res_sel;
        logic     out_load;
        t_status  out_status;
    } t_cmd;

    typedef struct packed {
        logic probe_done;
        logic slot_free;
        logic find_hit;
        logic find_end;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* design/lpht_req_if.sv */
// ----------------------------------------------------------------------------
// lpht_req_if
// Request channel: operation kind, handle and slot index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lpht_req_if;
    logic                          valid;
    logic                          ready;
    logic [lpht_pkg::KIND_W-1:0]   kind;
    logic [lpht_pkg::HANDLE_W-1:0] handle;
    logic [lpht_pkg::IDX_W-1:0]    slot_index;

    modport source (output valid, kind, handle, slot_index, input ready);
    modport sink   (input valid, kind, handle, slot_index, output ready);
endinterface

`default_nettype wire

/* design/lpht_rsp_if.sv */
// ----------------------------------------------------------------------------
// lpht_rsp_if
// Response channel: status and result slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lpht_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lpht_pkg::STATUS_W-1:0] status;
    logic [lpht_pkg::RES_W-1:0]    result_slot;

    modport source (output valid, status, result_slot, input ready);
    modport sink   (input valid, status, result_slot, output ready);
endinterface

`default_nettype wire

/* design/linear_probe_handle_table_unit.sv */
// ----------------------------------------------------------------------------
// linear_probe_handle_table_unit
// Open-addressing handle table with linear probing over a fixed slot set.
// ----------------------------------------------------------------------------
// One request is in work at a time; a finished response sits in an output
// register so the next request is taken while it waits. The home slot is
// the handle modulo TABLE_SIZE, a power of two, so it is the low handle bits.
// The probe walk then visits one slot a cycle: insert tests the occupied
// flags, find reads one key-memory entry a cycle through its single
// registered read port. The response is loaded once the output register
// is free, and a new request is taken the cycle after that load. Occupied
// flags are flip-flops cleared by reset, so there is no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_handle_table_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lpht_req_if.sink   i_req,
    lpht_rsp_if.source o_rsp
);

    lpht_pkg::t_cmd    cmd;
    lpht_pkg::t_sts    sts;
    lpht_pkg::t_status rsp_status;

    lpht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_kind  (i_req.kind),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lpht_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_handle      (i_req.handle),
        .i_slot_index  (i_req.slot_index),
        .i_out_ready   (o_rsp.ready),
        .o_sts         (sts),
        .o_out_valid   (o_rsp.valid),
        .o_status      (rsp_status),
        .o_result_slot (o_rsp.result_slot)
    );

    assign o_rsp.status = rsp_status;

endmodule

`default_nettype wire

/* design/lpht_ctrl.sv */
// ----------------------------------------------------------------------------
// lpht_ctrl
// Operation sequencer: probe walk, release and response hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_req_valid,
    input  wire logic [lpht_pkg::KIND_W-1:0] i_req_kind,
    output logic                             o_req_ready,
    input  wire lpht_pkg::t_sts              i_sts,
    output lpht_pkg::t_cmd                   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_INS,
        S_FIND,
        S_REL,
        S_RESP
    } t_state;

    t_state                      r_state,  n_state;
    logic [lpht_pkg::KIND_W-1:0] r_kind,   n_kind;
    lpht_pkg::t_status           r_status, n_status;

    always_comb begin
        n_state          = r_state;
        n_kind           = r_kind;
        n_status         = r_status;
        o_cmd            = '0;
        o_cmd.res_sel    = lpht_pkg::RES_ZERO;
        o_cmd.out_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    n_kind      = i_req_kind;
                    n_status    = lpht_pkg::ST_OK;
                    case (i_req_kind)
                        lpht_pkg::KIND_INSERT,
                        lpht_pkg::KIND_FIND: begin
                            n_state = S_INIT;
                        end
                        lpht_pkg::KIND_RELEASE: begin
                            n_state = S_REL;
                        end
                        default: begin
                            o_cmd.res_load = 1'b1;
                            n_state        = S_RESP;
                        end
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.probe_init = 1'b1;
                n_state = (r_kind == lpht_pkg::KIND_INSERT) ? S_INS : S_FIND;
            end
            S_INS: begin
                if (i_sts.probe_done) begin
                    o_cmd.res_load = 1'b1;
                    n_status       = lpht_pkg::ST_FULL;
                    n_state        = S_RESP;
                end else if (i_sts.slot_free) begin
                    o_cmd.ins_write = 1'b1;
                    o_cmd.res_load  = 1'b1;
                    o_cmd.res_sel   = lpht_pkg::RES_ADDR;
                    n_state         = S_RESP;
                end else begin
                    o_cmd.ins_step = 1'b1;
                end
            end
            S_FIND: begin
                o_cmd.find_en = 1'b1;
                if (i_sts.find_hit) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = lpht_pkg::RES_CHK;
                    n_state        = S_RESP;
                end else if (i_sts.find_end) begin
                    o_cmd.res_load = 1'b1;
                    n_status       = lpht_pkg::ST_MISSING;
                    n_state        = S_RESP;
                end
            end
            S_REL: begin
                o_cmd.rel_write = 1'b1;
                o_cmd.res_load  = 1'b1;
                n_state         = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= lpht_pkg::KIND_INSERT;
            r_status <= lpht_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_kind   <= n_kind;
            r_status <= n_status;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

/* design/lpht_dp.sv */
// ----------------------------------------------------------------------------
// lpht_dp
// Slot store, home-slot select, probe walk and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpht_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire lpht_pkg::t_cmd                i_cmd,
    input  wire logic [lpht_pkg::HANDLE_W-1:0] i_handle,
    input  wire logic [lpht_pkg::IDX_W-1:0]    i_slot_index,
    input  wire logic                          i_out_ready,
    output lpht_pkg::t_sts                     o_sts,
    output logic                               o_out_valid,
    output lpht_pkg::t_status                  o_status,
    output logic [lpht_pkg::RES_W-1:0]         o_result_slot
);

    localparam int SLOT_W = lpht_pkg::SLOT_W;
    localparam int CNT_W  = lpht_pkg::CNT_W;
    localparam int CMP_W  = (lpht_pkg::IDX_W > CNT_W) ? lpht_pkg::IDX_W : CNT_W;

    logic [lpht_pkg::HANDLE_W-1:0] r_handle;
    logic [lpht_pkg::IDX_W-1:0]    r_idx;

    logic [SLOT_W-1:0]             r_addr, n_addr;
    logic [CNT_W-1:0]              r_cnt;
    logic [lpht_pkg::TABLE_SIZE-1:0] r_used;
    logic [lpht_pkg::HANDLE_W-1:0] r_key_mem [lpht_pkg::TABLE_SIZE];
    logic [lpht_pkg::HANDLE_W-1:0] r_key_q;
    logic                          r_used_q;
    logic [SLOT_W-1:0]             r_chk_slot;
    logic                          r_chk_vld;

    logic [SLOT_W-1:0]             r_res_slot;
    logic                          r_out_vld;
    lpht_pkg::t_status             r_out_status;
    logic [lpht_pkg::RES_W-1:0]    r_out_slot;

    logic [SLOT_W-1:0]             home_slot;
    logic                          probe_last;
    logic                          issue;
    logic                          rel_ok;
    logic [SLOT_W-1:0]             rel_addr;

    assign home_slot  = SLOT_W'(r_handle % lpht_pkg::TABLE_SIZE);
    assign probe_last = (r_addr == SLOT_W'(lpht_pkg::TABLE_SIZE - 1));
    assign n_addr     = probe_last ? '0 : r_addr + 1'b1;
    assign issue      = i_cmd.find_en && (r_cnt != CNT_W'(lpht_pkg::TABLE_SIZE));
    assign rel_ok     = CMP_W'(r_idx) < CMP_W'(lpht_pkg::TABLE_SIZE);
    assign rel_addr   = SLOT_W'(r_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_handle <= i_handle;
            r_idx    <= i_slot_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.probe_init) begin
            r_addr <= home_slot;
            r_cnt  <= '0;
        end else if (i_cmd.ins_step || issue) begin
            r_addr <= n_addr;
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.ins_write) begin
            r_used[r_addr] <= 1'b1;
        end else if (i_cmd.rel_write && rel_ok) begin
            r_used[rel_addr] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_write) begin
            r_key_mem[r_addr] <= r_handle;
        end
        r_key_q    <= r_key_mem[r_addr];
        r_used_q   <= r_used[r_addr];
        r_chk_slot <= r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_vld <= 1'b0;
        end else begin
            r_chk_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            case (i_cmd.res_sel)
                lpht_pkg::RES_ADDR: r_res_slot <= r_addr;
                lpht_pkg::RES_CHK:  r_res_slot <= r_chk_slot;
                default:            r_res_slot <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_slot   <= lpht_pkg::RES_W'(r_res_slot);
        end
    end

    assign o_sts.probe_done = (r_cnt == CNT_W'(lpht_pkg::TABLE_SIZE));
    assign o_sts.slot_free  = !r_used[r_addr];
    assign o_sts.find_hit   = r_chk_vld && r_used_q && (r_key_q == r_handle);
    assign o_sts.find_end   = (r_cnt == CNT_W'(lpht_pkg::TABLE_SIZE)) && !r_chk_vld;
    assign o_sts.out_free   = !r_out_vld || i_out_ready;

    assign o_out_valid   = r_out_vld;
    assign o_status      = r_out_status;
    assign o_result_slot = r_out_slot;

endmodule

`default_nettype wire

/* design/lpht_checker.sv */
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks on the handle table request and response channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "linear_probe_handle_table_unit_macros.svh"

module lpht_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_req_valid,
    input wire logic                          i_req_ready,
    input wire logic                          i_rsp_valid,
    input wire logic                          i_rsp_ready,
    input wire logic [lpht_pkg::STATUS_W-1:0] i_status,
    input wire logic [lpht_pkg::RES_W-1:0]    i_result_slot
);

    logic req_xact;
    logic status_known;
    logic status_fail;

    assign req_xact     = i_req_valid && i_req_ready;
    assign status_known = (i_status == lpht_pkg::ST_OK) || (i_status == lpht_pkg::ST_FULL)
                       || (i_status == lpht_pkg::ST_MISSING);
    assign status_fail  = (i_status == lpht_pkg::ST_FULL) || (i_status == lpht_pkg::ST_MISSING);

    `LPHT_ASSERT_IMPL(a_status_code, i_rsp_valid, status_known)
    `LPHT_ASSERT_IMPL(a_fail_slot_zero, i_rsp_valid && status_fail, i_result_slot == '0)
    `LPHT_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_status) && $stable(i_result_slot))
    `LPHT_ASSERT_NEXT(a_req_busy, req_xact, !i_req_ready)
    `LPHT_ASSERT_RESET(a_reset_quiet, !i_rst_n, !i_rsp_valid && i_req_ready)

endmodule

bind linear_probe_handle_table_unit lpht_checker u_lpht_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_result_slot (o_rsp.result_slot)
);

`default_nettype wire

/* tb/sv/lpht_table_checker.sv */
// ----------------------------------------------------------------------------
// lpht_table_checker
// Watches the request and response channels of the handle table, keeps its
// own copy of the occupied flags and stored handles, works out the status
// and slot of every accepted request and compares each accepted response
// against the oldest outstanding outcome.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_table_checker
    import lpht_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpht_req_if        i_req,
    lpht_rsp_if        i_rsp,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        t_status          status;
        logic [RES_W-1:0] slot;
    } t_table_outcome;

    logic                table_used [TABLE_SIZE];
    logic [HANDLE_W-1:0] table_key  [TABLE_SIZE];
    t_table_outcome      outcome_q  [$];
    int                  mismatch_count = 0;
    int                  outstanding    = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = outstanding;

    function automatic t_table_outcome apply_table_op(logic [KIND_W-1:0]   kind,
                                                      logic [HANDLE_W-1:0] handle,
                                                      logic [IDX_W-1:0]    idx);
        t_table_outcome res;
        int             probe;
        int             n;
        bit             hit;
        res.status = ST_OK;
        res.slot   = '0;
        hit        = 1'b0;
        probe      = int'(handle) % TABLE_SIZE;
        case (kind)
            KIND_INSERT: begin
                for (n = 0; n < TABLE_SIZE && !hit; n++) begin
                    if (!table_used[probe])
                        hit = 1'b1;
                    else
                        probe = (probe + 1) % TABLE_SIZE;
                end
                if (hit) begin
                    table_used[probe] = 1'b1;
                    table_key[probe]  = handle;
                    res.slot          = RES_W'(probe);
                end else begin
                    res.status = ST_FULL;
                end
            end
            KIND_FIND: begin
                for (n = 0; n < TABLE_SIZE && !hit; n++) begin
                    if (table_used[probe] && table_key[probe] == handle)
                        hit = 1'b1;
                    else
                        probe = (probe + 1) % TABLE_SIZE;
                end
                if (hit)
                    res.slot = RES_W'(probe);
                else
                    res.status = ST_MISSING;
            end
            KIND_RELEASE: begin
                if (int'(idx) < TABLE_SIZE)
                    table_used[idx] = 1'b0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [STATUS_W-1:0] got_status,
                                   logic [RES_W-1:0] got_slot, t_table_outcome want);
        mismatch_count++;
        $display("%0t lpht mismatch: %s: got status %0d slot %0d, want status %0d slot %0d",
                 $time, what, got_status, got_slot, want.status, want.slot);
    endtask

    always @(posedge i_clk) begin
        t_table_outcome want;
        if (!i_rst_n) begin
            foreach (table_used[s])
                table_used[s] = 1'b0;
            outcome_q.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (outcome_q.size() == 0) begin
                    want = '0;
                    report_mismatch("response with no request outstanding",
                                    i_rsp.status, i_rsp.result_slot, want);
                end else begin
                    want = outcome_q.pop_front();
                    if (i_rsp.status !== want.status)
                        report_mismatch("status", i_rsp.status, i_rsp.result_slot, want);
                    if (i_rsp.result_slot !== want.slot)
                        report_mismatch("result_slot", i_rsp.status, i_rsp.result_slot, want);
                end
            end
            if (i_req.valid && i_req.ready)
                outcome_q.push_back(apply_table_op(i_req.kind, i_req.handle, i_req.slot_index));
        end
        outstanding = outcome_q.size();
    end

endmodule

/* tb/sv/tb_linear_probe_handle_table_unit.sv */
// ----------------------------------------------------------------------------
// tb_linear_probe_handle_table_unit
// Drives insert, find, release and unused-kind requests into the handle
// table: a directed opening on wrap, collisions, duplicates and holes, then
// episodes that fill the table to full, churn it and drain it, with random
// idle gaps on both channels and one long response hold-off. The checker
// beside the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_linear_probe_handle_table_unit;
    import lpht_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int POOL_DEPTH  = 64;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 1500;
    localparam int DRAIN_WAIT  = 200;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   sent       = 0;
    bit   quiet_src  = 1'b0;
    bit   quiet_snk  = 1'b0;
    bit   held_off   = 1'b0;

    logic [HANDLE_W-1:0] handle_pool [$];

    lpht_req_if req_if ();
    lpht_rsp_if rsp_if ();

    linear_probe_handle_table_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    lpht_table_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("tb_linear_probe_handle_table_unit: FAIL");
        $finish;
    end

    function automatic int idle_len(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(60, 12);
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_handle();
        int                  r;
        logic [HANDLE_W-1:0] h;
        r = $urandom_range(99);
        if (r < 40 && handle_pool.size() > 0)
            return handle_pool[$urandom_range(handle_pool.size() - 1)];
        h = HANDLE_W'($urandom);
        // cluster around the wrap point
        if (r < 70)
            h[IDX_W-1:0] = IDX_W'($urandom_range(3) + TABLE_SIZE - 3);
        return h;
    endfunction

    task automatic send_req(logic [KIND_W-1:0] kind, logic [HANDLE_W-1:0] handle,
                            logic [IDX_W-1:0] idx);
        int gap;
        req_if.valid      <= 1'b1;
        req_if.kind       <= kind;
        req_if.handle     <= handle;
        req_if.slot_index <= idx;
        do @(posedge i_clk); while (!req_if.ready);
        sent++;
        if (kind == KIND_INSERT) begin
            handle_pool.push_back(handle);
            if (handle_pool.size() > POOL_DEPTH)
                void'(handle_pool.pop_front());
        end
        gap = idle_len(quiet_src);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic run_episode(int count, int ins_pct, int find_pct, int rel_pct);
        int                  i;
        int                  r;
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [IDX_W-1:0]    idx;
        for (i = 0; i < count; i++) begin
            if (sent % 50 == 0)
                quiet_src = ($urandom_range(3) == 0);
            r = $urandom_range(99);
            if (r < ins_pct)
                kind = KIND_INSERT;
            else if (r < ins_pct + find_pct)
                kind = KIND_FIND;
            else if (r < ins_pct + find_pct + rel_pct)
                kind = KIND_RELEASE;
            else
                kind = KIND_UNUSED;
            handle = pick_handle();
            // aim half the releases at home slots of recently inserted handles
            if ($urandom_range(1) == 0 && handle_pool.size() > 0)
                idx = handle_pool[$urandom_range(handle_pool.size() - 1)][IDX_W-1:0];
            else
                idx = IDX_W'($urandom_range(TABLE_SIZE - 1));
            send_req(kind, handle, idx);
        end
    endtask

    initial begin
        int n;
        int iter;
        rsp_if.ready <= 1'b0;
        iter = 0;
        forever begin
            @(posedge i_clk);
            iter++;
            if (iter % 100 == 0)
                quiet_snk = ($urandom_range(3) == 0);
            if (!held_off && sent >= HOLD_AT) begin
                held_off = 1'b1;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                n = idle_len(quiet_snk);
                if (n == 0) begin
                    rsp_if.ready <= 1'b1;
                end else begin
                    rsp_if.ready <= 1'b0;
                    repeat (n - 1) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.kind       <= KIND_INSERT;
        req_if.handle     <= '0;
        req_if.slot_index <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(KIND_FIND,    16'h0000, 7'd0);
        send_req(KIND_RELEASE, 16'h0000, 7'd0);
        send_req(KIND_INSERT,  16'hFFFF, 7'd0);
        send_req(KIND_INSERT,  16'h007F, 7'd127);
        send_req(KIND_INSERT,  16'h0000, 7'd0);
        send_req(KIND_FIND,    16'h007F, 7'd0);
        send_req(KIND_FIND,    16'h0000, 7'd0);
        send_req(KIND_INSERT,  16'hFFFF, 7'd0);
        send_req(KIND_FIND,    16'hFFFF, 7'd0);
        send_req(KIND_RELEASE, 16'hFFFF, 7'd127);
        send_req(KIND_FIND,    16'hFFFF, 7'd0);
        send_req(KIND_RELEASE, 16'h0000, 7'd127);
        send_req(KIND_FIND,    16'h1234, 7'd0);
        send_req(KIND_UNUSED,  16'h8000, 7'd127);
        send_req(KIND_INSERT,  16'h8001, 7'd64);
        send_req(KIND_FIND,    16'h8001, 7'd0);

        run_episode(200, 75, 20, 3);
        run_episode(200, 40, 40, 17);
        run_episode(200, 10, 30, 58);
        run_episode(250, 80, 15, 3);
        run_episode(200, 40, 40, 17);
        run_episode(200, 70, 25, 3);
        run_episode(150, 10, 30, 58);
        run_episode(200, 40, 40, 17);
        req_if.valid <= 1'b0;

        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_linear_probe_handle_table_unit: PASS");
        else
            $display("tb_linear_probe_handle_table_unit: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/lpht_pkg.sv
design/lpht_req_if.sv
design/lpht_rsp_if.sv
design/lpht_ctrl.sv
design/lpht_dp.sv
design/linear_probe_handle_table_unit.sv
design/lpht_checker.sv
tb/sv/lpht_table_checker.sv
tb/sv/tb_linear_probe_handle_table_unit.sv
